### src/frame_stream_deframer_assert.svh
// Assertion macros for the frame stream deframer.
// Each macro compiles to nothing in synthesis.
`ifndef FRAME_STREAM_DEFRAMER_ASSERT_SVH
`define FRAME_STREAM_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FSDF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsdf assertion failed");

// Next-cycle implication.
`define FSDF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fsdf assertion failed");

`else

`define FSDF_ASSERT_IMP(name, clk, rst, ante, cons)
`define FSDF_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### src/fsdf_pkg.sv
package fsdf_pkg;

   localparam int HEADER_BYTES = 32;
   localparam int PIXEL_BYTES  = 4;
   localparam int HDR_BITS     = HEADER_BYTES * 8;
   localparam int CNT_W        = 32;
   localparam int EXPECT_W     = 32 + $clog2(PIXEL_BYTES);

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 144;
   localparam int RSP_USER_W   = 2;

   // header byte offsets
   localparam int OFS_MAGIC    = 0;
   localparam int OFS_VERSION  = 4;
   localparam int OFS_HDR_SIZE = 6;
   localparam int OFS_WIDTH    = 8;
   localparam int OFS_HEIGHT   = 12;
   localparam int OFS_FORMAT   = 16;
   localparam int OFS_PAYLOAD  = 20;
   localparam int OFS_SEQUENCE = 24;

   // 'P','T','S','B' read little-endian
   localparam logic [31:0] MAGIC_WORD = 32'h4253_5450;

   localparam logic [CSR_IDX_W-1:0] CSR_EXP_VERSION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FMT_CODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 3'd4;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_MAGIC        = 3'd0,
      ERR_VERSION      = 3'd1,
      ERR_HDR_SIZE     = 3'd2,
      ERR_FORMAT       = 3'd3,
      ERR_DIMENSIONS   = 3'd4,
      ERR_PAYLOAD_SIZE = 3'd5,
      ERR_STOPPED      = 3'd6
   } err_type;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_STOPPED = 2'd2
   } phase_type;

   typedef struct packed {
      logic [15:0] exp_version;
      logic [31:0] fmt_code;
      logic [15:0] max_width;
      logic [15:0] max_height;
      logic [31:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic    fail;
      err_type code;
   } chk_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pixel;
      logic        frame_end;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] payload;
      logic [63:0] seq;
      err_type     err;
   } rsp_type;

   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] size;
   } status_type;

endpackage

### src/fsdf_csr.sv
module fsdf_csr
   import fsdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EXP_VERSION: cfg_in.exp_version = csr_wdata[15:0];
            CSR_FMT_CODE:    cfg_in.fmt_code    = csr_wdata[31:0];
            CSR_MAX_WIDTH:   cfg_in.max_width   = csr_wdata[15:0];
            CSR_MAX_HEIGHT:  cfg_in.max_height  = csr_wdata[15:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata[31:0];
            default:         cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exp_version <= 16'd1;
         cfg_ff.fmt_code    <= 32'd0;
         cfg_ff.max_width   <= 16'd8192;
         cfg_ff.max_height  <= 16'd8192;
         cfg_ff.max_payload <= 32'd268435456;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/fsdf_hdr_check.sv
module fsdf_hdr_check
   import fsdf_pkg::*;
(
   input  logic [HDR_BITS-1:0] hdr,
   input  cfg_type             cfg,
   output chk_type             chk
);

   logic [31:0]         w32, h32, fmt, psize;
   logic [31:0]         area;
   logic [EXPECT_W-1:0] expect_bytes;
   logic                dims_bad;

   assign w32   = hdr[OFS_WIDTH*8   +: 32];
   assign h32   = hdr[OFS_HEIGHT*8  +: 32];
   assign fmt   = hdr[OFS_FORMAT*8  +: 32];
   assign psize = hdr[OFS_PAYLOAD*8 +: 32];

   assign dims_bad = (w32 == '0) || (h32 == '0) ||
                     (w32 > {16'd0, cfg.max_width}) || (h32 > {16'd0, cfg.max_height});

   // only meaningful when the dimensions passed, so 16 bits each suffice
   assign area         = 32'(w32[15:0]) * 32'(h32[15:0]);
   assign expect_bytes = EXPECT_W'(area) * EXPECT_W'(PIXEL_BYTES);

   always_comb begin
      chk.fail = 1'b1;
      chk.code = ERR_MAGIC;
      priority if (hdr[OFS_MAGIC*8 +: 32] != MAGIC_WORD) begin
         chk.code = ERR_MAGIC;
      end else if (hdr[OFS_VERSION*8 +: 16] != cfg.exp_version) begin
         chk.code = ERR_VERSION;
      end else if (hdr[OFS_HDR_SIZE*8 +: 16] != 16'(HEADER_BYTES)) begin
         chk.code = ERR_HDR_SIZE;
      end else if (fmt != cfg.fmt_code) begin
         chk.code = ERR_FORMAT;
      end else if (dims_bad) begin
         chk.code = ERR_DIMENSIONS;
      end else if ((expect_bytes > EXPECT_W'(cfg.max_payload)) ||
                   (EXPECT_W'(psize) != expect_bytes)) begin
         chk.code = ERR_PAYLOAD_SIZE;
      end else begin
         chk.fail = 1'b0;
      end
   end

endmodule

### src/fsdf_parser.sv
module fsdf_parser
   import fsdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   input  logic       in_cmd,
   input  logic [7:0] in_byte,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    rsp,
   output status_type status
);

   phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]    count_ff, count_in, count_plus;
   logic [CNT_W-1:0]    size_ff, size_in;
   logic [HDR_BITS-1:0] hdr_ff, hdr_in, hdr_now;
   logic                out_valid_ff, out_valid_in;
   rsp_type             rsp_ff, res;
   logic                res_valid;
   logic                fire, byte_fire, hdr_last, pay_last;
   chk_type             chk;

   assign in_ready   = !out_valid_ff || out_ready;
   assign fire       = in_valid && in_ready;
   assign byte_fire  = fire && !in_cmd;
   assign count_plus = count_ff + CNT_W'(1);
   assign hdr_last   = (count_ff == CNT_W'(HEADER_BYTES - 1));
   assign pay_last   = (count_plus >= size_ff);

   // header as it stands once this byte lands
   assign hdr_now = {in_byte, hdr_ff[HDR_BITS-1:8]};

   fsdf_hdr_check u_check (
      .hdr (hdr_now),
      .cfg (cfg),
      .chk (chk)
   );

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      size_in  = size_ff;
      hdr_in   = hdr_ff;
      if (fire && in_cmd) begin
         phase_in = PH_HEADER;
         count_in = '0;
         size_in  = '0;
      end else if (byte_fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               hdr_in = hdr_now;
               if (hdr_last) begin
                  count_in = '0;
                  if (chk.fail) begin
                     phase_in = PH_STOPPED;
                  end else begin
                     phase_in = PH_PAYLOAD;
                     size_in  = hdr_now[OFS_PAYLOAD*8 +: 32];
                  end
               end else begin
                  count_in = count_plus;
               end
            end
            PH_PAYLOAD: begin
               if (pay_last) begin
                  phase_in = PH_HEADER;
                  count_in = '0;
                  size_in  = '0;
               end else begin
                  count_in = count_plus;
               end
            end
            PH_STOPPED: phase_in = PH_STOPPED;
            default:    phase_in = PH_HEADER;
         endcase
      end
   end

   // result of the current byte
   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      if (byte_fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_last) begin
                  res_valid = 1'b1;
                  if (chk.fail) begin
                     res.kind = KIND_ERROR;
                     res.err  = chk.code;
                  end else begin
                     res.kind    = KIND_HEADER;
                     res.width   = hdr_now[OFS_WIDTH*8    +: 16];
                     res.height  = hdr_now[OFS_HEIGHT*8   +: 16];
                     res.payload = hdr_now[OFS_PAYLOAD*8  +: 32];
                     res.seq     = hdr_now[OFS_SEQUENCE*8 +: 64];
                  end
               end
            end
            PH_PAYLOAD: begin
               res_valid     = 1'b1;
               res.kind      = KIND_PAYLOAD;
               res.pixel     = in_byte;
               res.frame_end = pay_last;
            end
            PH_STOPPED: begin
               res_valid = 1'b1;
               res.kind  = KIND_ERROR;
               res.err   = ERR_STOPPED;
            end
            default: res_valid = 1'b0;
         endcase
      end
   end

   assign out_valid_in = fire ? res_valid : (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         size_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         size_ff      <= size_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (fire && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign out_valid    = out_valid_ff;
   assign rsp          = rsp_ff;
   assign status.phase = phase_ff;
   assign status.count = count_ff;
   assign status.size  = size_ff;

endmodule

### src/frame_stream_deframer.sv
// Frame stream deframer. Takes one stream byte (or a parser-reset command,
// req_tuser = 1) per request and gives at most one result per request: a
// header result once all 32 header bytes are in and pass the checks (magic,
// version, header size, pixel format, dimensions, payload size equal to
// width*height*4 and <= max_payload), then one result per payload byte with
// rsp_tlast on the last byte of the frame, or one error result on a failed
// check, after which every byte is answered with a "stopped" error until a
// reset command. Throughput is one request per clock unless stalled; each
// passes the input register, then the parse/check stage into the result
// register. The header check, including the 16x16 width*height multiply,
// runs in the single cycle in which the 32nd header byte is parsed. Header
// bytes before the last and reset commands produce no result. Config
// registers may be written whenever no request is in flight.
`include "frame_stream_deframer_assert.svh"

module frame_stream_deframer
   import fsdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] stream_byte
   input  logic                  req_tuser,   // [0] cmd: 1 = reset parser

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] pixel_byte, [23:8] frame_width, [39:24] frame_height,
   // [71:40] payload_length, [135:72] sequence_number,
   // [138:136] error_code, [143:139] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast,   // frame_end

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   rsp_type    rsp;
   status_type status;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       proc_ready;
   logic       proc_fire;
   logic       req_fire;

   assign proc_fire  = in_valid_ff && proc_ready;
   assign req_tready = !in_valid_ff || proc_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !proc_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   fsdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // parse/check stage with result register
   fsdf_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_cmd    (in_cmd_ff),
      .in_byte   (in_byte_ff),
      .in_ready  (proc_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .rsp       (rsp),
      .status    (status)
   );

   assign rsp_tdata = {5'd0, rsp.err, rsp.seq, rsp.payload, rsp.height, rsp.width, rsp.pixel};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.frame_end;

   // frame end only ever marks a payload byte
   `FSDF_ASSERT_IMP(a_tlast_payload, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_PAYLOAD)

   // the payload counter never reaches the frame size while in a frame
   `FSDF_ASSERT_IMP(a_count_in_frame, clock, reset, status.phase == PH_PAYLOAD, status.count < status.size)

   // a reset command returns the parser to the start of a header
   `FSDF_ASSERT_NEXT(a_cmd_clears, clock, reset, proc_fire && in_cmd_ff, status.phase == PH_HEADER && status.count == '0)

endmodule
